/* hdl/sigmoid_activation_unit_top_assert.svh */
// Assertion macros shared by the sigmoid activation unit RTL.
`ifndef SIGMOID_ACTIVATION_UNIT_TOP_ASSERT_SVH
`define SIGMOID_ACTIVATION_UNIT_TOP_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SAU_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define SAU_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/sau_pkg.sv */
// Types and constants of the sigmoid activation unit.
package sau_pkg;

    localparam logic OP_FORWARD  = 1'b0;
    localparam logic OP_BACKWARD = 1'b1;

    localparam int unsigned FRAC_W  = 10;
    localparam int unsigned WHOLE_W = 4;
    localparam int unsigned TERM_W  = 30;
    localparam int unsigned SUM_W   = 32;
    localparam int unsigned P_W     = 31;
    localparam int unsigned D_W     = 32;
    localparam int unsigned NUM_W   = 48;
    localparam int unsigned QUO_W   = 17;

    localparam logic signed [15:0] CLAMP_POS = 16'sd30720;
    localparam logic signed [15:0] CLAMP_NEG = -16'sd30720;

    localparam logic [WHOLE_W-1:0] WHOLE_CAP    = 4'd12;
    localparam int unsigned        SCALE_STAGES = 12;

    localparam int unsigned TERM_FIRST = 2;
    localparam int unsigned TERM_LAST  = 12;

    localparam logic [P_W-1:0] Q_ONE           = 31'h4000_0000;
    localparam logic [28:0]    EXP_NEG_ONE_Q30 = 29'd395007542;
    localparam logic [15:0]    ACT_MAX         = 16'hFFFF;

    typedef struct packed {
        logic               opcode;
        logic signed [15:0] pre_activation;
        logic [15:0]        activation;
        logic signed [15:0] upstream_gradient;
    } t_in_item;

    typedef struct packed {
        logic [15:0]        activation_out;
        logic signed [15:0] input_gradient;
    } t_out_item;

    typedef struct packed {
        logic               opcode;
        logic               pos;
        logic [WHOLE_W-1:0] whole;
        logic signed [15:0] grad;
    } t_side;

endpackage

/* hdl/sau_front.sv */
// Input stages: clamp and split of x, and the backward gradient product.
module sau_front import sau_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  t_in_item          i_item,
    output logic              o_valid,
    output t_side             o_side,
    output logic [FRAC_W-1:0] o_frac
);

    logic signed [15:0] xc;
    logic [14:0]        mag_x;
    logic [4:0]         whole_full;
    logic [33:0]        yy_full;
    logic [15:0]        gmag;

    logic              r1_valid;
    t_side             r1_side;
    logic [FRAC_W-1:0] r1_frac;
    logic [30:0]       r1_yy;
    logic [15:0]       r1_gmag;
    logic              r1_gneg;

    logic [46:0]        prod;
    logic [14:0]        q15;
    logic signed [15:0] n_grad;
    t_side              n_side;

    logic              r2_valid;
    t_side             r2_side;
    logic [FRAC_W-1:0] r2_frac;

    always_comb begin
        if (i_item.pre_activation > CLAMP_POS) begin
            xc = CLAMP_POS;
        end else if (i_item.pre_activation < CLAMP_NEG) begin
            xc = CLAMP_NEG;
        end else begin
            xc = i_item.pre_activation;
        end
        mag_x      = xc[15] ? 15'(-xc) : xc[14:0];
        whole_full = mag_x[14:10];
        yy_full    = 34'(i_item.activation) * 34'(17'h10000 - 17'(i_item.activation));
        gmag       = i_item.upstream_gradient[15] ? 16'(-i_item.upstream_gradient)
                                                  : 16'(i_item.upstream_gradient);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_side.opcode <= i_item.opcode;
            r1_side.pos    <= !i_item.pre_activation[15] && (i_item.pre_activation != 16'sd0);
            r1_side.whole  <= (whole_full > 5'(WHOLE_CAP)) ? WHOLE_CAP : whole_full[3:0];
            r1_side.grad   <= '0;
            r1_frac        <= mag_x[FRAC_W-1:0];
            r1_yy          <= yy_full[30:0];
            r1_gmag        <= gmag;
            r1_gneg        <= i_item.upstream_gradient[15];
        end
    end

    always_comb begin
        prod   = 47'(r1_yy) * 47'(r1_gmag);
        q15    = prod[46:32];
        n_grad = r1_gneg ? -$signed({1'b0, q15}) : $signed({1'b0, q15});
        n_side = r1_side;
        n_side.grad = (r1_side.opcode == OP_BACKWARD) ? n_grad : 16'sd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_side <= n_side;
            r2_frac <= r1_frac;
        end
    end

    assign o_valid = r2_valid;
    assign o_side  = r2_side;
    assign o_frac  = r2_frac;

endmodule

/* hdl/sau_series.sv */
// Taylor series pipeline for exp(-f) in Q30, three stages per term.
module sau_series import sau_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  t_side             i_side,
    input  logic [FRAC_W-1:0] i_frac,
    output logic              o_valid,
    output t_side             o_side,
    output logic [P_W-1:0]    o_p
);

    localparam int unsigned NT = TERM_LAST - TERM_FIRST + 1;

    logic                    w_valid [0:NT];
    t_side                   w_side  [0:NT];
    logic [FRAC_W-1:0]       w_frac  [0:NT];
    logic [TERM_W-1:0]       w_term  [0:NT];
    logic signed [SUM_W-1:0] w_sum   [0:NT];

    // The first term is f itself, so the series starts at the second term.
    assign w_valid[0] = i_valid;
    assign w_side[0]  = i_side;
    assign w_frac[0]  = i_frac;
    assign w_term[0]  = TERM_W'({i_frac, 20'd0});
    assign w_sum[0]   = $signed(SUM_W'(Q_ONE) - SUM_W'(w_term[0]));

    for (genvar k = 0; k < NT; k++) begin : g_term
        localparam int unsigned       N       = k + TERM_FIRST;
        localparam logic [TERM_W-1:0] RECIP   = TERM_W'((64'd1 << 30) / N);
        localparam logic [3:0]        DIVISOR = 4'(N);
        localparam bit                ODD     = (N % 2) == 1;

        logic                    ra_valid;
        t_side                   ra_side;
        logic [FRAC_W-1:0]       ra_frac;
        logic signed [SUM_W-1:0] ra_sum;
        logic [TERM_W-1:0]       ra_v;

        logic                    rb_valid;
        t_side                   rb_side;
        logic [FRAC_W-1:0]       rb_frac;
        logic signed [SUM_W-1:0] rb_sum;
        logic [TERM_W-1:0]       rb_v;
        logic [TERM_W-1:0]       rb_q0;

        logic                    rc_valid;
        t_side                   rc_side;
        logic [FRAC_W-1:0]       rc_frac;
        logic signed [SUM_W-1:0] rc_sum;
        logic [TERM_W-1:0]       rc_term;

        logic [39:0]             prod_a;
        logic [59:0]             prod_b;
        logic [TERM_W-1:0]       prod_c;
        logic [TERM_W-1:0]       rem;
        logic [TERM_W-1:0]       n_term;
        logic signed [SUM_W-1:0] n_sum;

        always_comb begin
            prod_a = 40'(w_term[k]) * 40'(w_frac[k]);
            prod_b = 60'(ra_v) * 60'(RECIP);
            prod_c = rb_q0 * TERM_W'(DIVISOR);
            rem    = rb_v - prod_c;
            n_term = (rem >= TERM_W'(DIVISOR)) ? rb_q0 + TERM_W'(1) : rb_q0;
            if (ODD) begin
                n_sum = rb_sum - $signed(SUM_W'(n_term));
            end else begin
                n_sum = rb_sum + $signed(SUM_W'(n_term));
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                ra_valid <= 1'b0;
                rb_valid <= 1'b0;
                rc_valid <= 1'b0;
            end else if (i_en) begin
                ra_valid <= w_valid[k];
                rb_valid <= ra_valid;
                rc_valid <= rb_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                ra_side <= w_side[k];
                ra_frac <= w_frac[k];
                ra_sum  <= w_sum[k];
                ra_v    <= prod_a[39:10];
                rb_side <= ra_side;
                rb_frac <= ra_frac;
                rb_sum  <= ra_sum;
                rb_v    <= ra_v;
                rb_q0   <= prod_b[59:30];
                rc_side <= rb_side;
                rc_frac <= rb_frac;
                rc_sum  <= n_sum;
                rc_term <= n_term;
            end
        end

        assign w_valid[k+1] = rc_valid;
        assign w_side[k+1]  = rc_side;
        assign w_frac[k+1]  = rc_frac;
        assign w_term[k+1]  = rc_term;
        assign w_sum[k+1]   = rc_sum;
    end

    assign o_valid = w_valid[NT];
    assign o_side  = w_side[NT];
    assign o_p     = (w_sum[NT] > 0) ? P_W'(w_sum[NT]) : '0;

endmodule

/* hdl/sau_scale.sv */
// Multiplier chain that applies exp(-1) once per whole unit of |x|.
module sau_scale import sau_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  t_side          i_side,
    input  logic [P_W-1:0] i_p,
    output logic           o_valid,
    output t_side          o_side,
    output logic [P_W-1:0] o_p
);

    logic           w_valid [0:SCALE_STAGES];
    t_side          w_side  [0:SCALE_STAGES];
    logic [P_W-1:0] w_p     [0:SCALE_STAGES];

    assign w_valid[0] = i_valid;
    assign w_side[0]  = i_side;
    assign w_p[0]     = i_p;

    // Whole parts beyond the cap give a value small enough that both output
    // branches already settle, so the chain stops at the cap.
    for (genvar j = 0; j < SCALE_STAGES; j++) begin : g_stage
        localparam logic [WHOLE_W-1:0] IDX = WHOLE_W'(j);

        logic           r_valid;
        t_side          r_side;
        logic [P_W-1:0] r_p;
        logic [60:0]    prod;
        logic [P_W-1:0] n_p;

        always_comb begin
            prod = 61'(w_p[j]) * 61'(EXP_NEG_ONE_Q30);
            n_p  = (w_side[j].whole > IDX) ? prod[60:30] : w_p[j];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid <= 1'b0;
            end else if (i_en) begin
                r_valid <= w_valid[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side <= w_side[j];
                r_p    <= n_p;
            end
        end

        assign w_valid[j+1] = r_valid;
        assign w_side[j+1]  = r_side;
        assign w_p[j+1]     = r_p;
    end

    assign o_valid = w_valid[SCALE_STAGES];
    assign o_side  = w_side[SCALE_STAGES];
    assign o_p     = w_p[SCALE_STAGES];

endmodule

/* hdl/sau_div.sv */
// Rounded division pipeline producing the sigmoid quotient one bit per stage.
module sau_div import sau_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  t_side            i_side,
    input  logic [P_W-1:0]   i_p,
    output logic             o_valid,
    output t_side            o_side,
    output logic [QUO_W-1:0] o_quo
);

    logic [D_W-1:0]   d;
    logic [NUM_W-1:0] num;

    logic             r0_valid;
    t_side            r0_side;
    logic [D_W-1:0]   r0_d;
    logic [NUM_W-1:0] r0_num;

    logic             w_valid [0:QUO_W];
    t_side            w_side  [0:QUO_W];
    logic [D_W-1:0]   w_d     [0:QUO_W];
    logic [NUM_W-1:0] w_rem   [0:QUO_W];
    logic [QUO_W-1:0] w_quo   [0:QUO_W];

    always_comb begin
        d   = D_W'(Q_ONE) + D_W'(i_p);
        num = i_side.pos ? (NUM_W'(1) << 46) : (NUM_W'(i_p) << 16);
        num = num + NUM_W'(d >> 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else if (i_en) begin
            r0_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_side <= i_side;
            r0_d    <= d;
            r0_num  <= num;
        end
    end

    assign w_valid[0] = r0_valid;
    assign w_side[0]  = r0_side;
    assign w_d[0]     = r0_d;
    assign w_rem[0]   = r0_num;
    assign w_quo[0]   = '0;

    for (genvar k = 0; k < QUO_W; k++) begin : g_bit
        localparam int unsigned B = QUO_W - 1 - k;

        logic             r_valid;
        t_side            r_side;
        logic [D_W-1:0]   r_d;
        logic [NUM_W-1:0] r_rem;
        logic [QUO_W-1:0] r_quo;
        logic [NUM_W-1:0] shifted_d;
        logic             take;

        always_comb begin
            shifted_d = NUM_W'(w_d[k]) << B;
            take      = w_rem[k] >= shifted_d;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid <= 1'b0;
            end else if (i_en) begin
                r_valid <= w_valid[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side <= w_side[k];
                r_d    <= w_d[k];
                r_rem  <= take ? w_rem[k] - shifted_d : w_rem[k];
                r_quo  <= w_quo[k] | (QUO_W'(take) << B);
            end
        end

        assign w_valid[k+1] = r_valid;
        assign w_side[k+1]  = r_side;
        assign w_d[k+1]     = r_d;
        assign w_rem[k+1]   = r_rem;
        assign w_quo[k+1]   = r_quo;
    end

    assign o_valid = w_valid[QUO_W];
    assign o_side  = w_side[QUO_W];
    assign o_quo   = w_quo[QUO_W];

endmodule

/* hdl/sigmoid_activation_unit_top.sv */
// Top level of the fixed-point logistic sigmoid unit, forward and backward.
//
// Channel   Role     Handshake                   Payload
// input     item in  i_in_valid / o_in_ready     i_in_item  (t_in_item)
// output    item out o_out_valid / i_out_ready   o_out_item (t_out_item)
//
// One item is accepted per cycle while o_in_ready is high; results leave in order of acceptance.
// Stages: two input, 33 series, 12 exp(-1) multiplier, 18 divider and the output register.
// Reset clears the valid bits of all stages and of the output register.
// The whole pipeline holds as one only when its last stage and the output
// register are both full and the output is not taken.
`include "sigmoid_activation_unit_top_assert.svh"

module sigmoid_activation_unit_top import sau_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    logic             en;

    logic             front_valid;
    t_side            front_side;
    logic [FRAC_W-1:0] front_frac;

    logic             series_valid;
    t_side            series_side;
    logic [P_W-1:0]   series_p;

    logic             scale_valid;
    t_side            scale_side;
    logic [P_W-1:0]   scale_p;

    logic             div_valid;
    t_side            div_side;
    logic [QUO_W-1:0] div_quo;

    logic             r_out_valid;
    logic             n_out_valid;
    t_out_item        r_out_item;
    t_out_item        n_out_item;
    logic [15:0]      act_sat;

    assign en         = !div_valid || !r_out_valid || i_out_ready;
    assign o_in_ready = en;

    sau_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_item  (i_in_item),
        .o_valid (front_valid),
        .o_side  (front_side),
        .o_frac  (front_frac)
    );

    sau_series u_series (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (front_valid),
        .i_side  (front_side),
        .i_frac  (front_frac),
        .o_valid (series_valid),
        .o_side  (series_side),
        .o_p     (series_p)
    );

    sau_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (series_valid),
        .i_side  (series_side),
        .i_p     (series_p),
        .o_valid (scale_valid),
        .o_side  (scale_side),
        .o_p     (scale_p)
    );

    sau_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (scale_valid),
        .i_side  (scale_side),
        .i_p     (scale_p),
        .o_valid (div_valid),
        .o_side  (div_side),
        .o_quo   (div_quo)
    );

    always_comb begin
        act_sat     = div_quo[QUO_W-1] ? ACT_MAX : div_quo[15:0];
        n_out_valid = (r_out_valid && !i_out_ready) || (en && div_valid);
        n_out_item.activation_out = (div_side.opcode == OP_BACKWARD) ? 16'd0 : act_sat;
        n_out_item.input_gradient = div_side.grad;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && div_valid) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    `SAU_ASSERT_SAME(a_full_stalls_input,
        r_out_valid && !i_out_ready && div_valid, !o_in_ready,
        "input accepted while the pipeline end is blocked")
    `SAU_ASSERT_NEXT(a_last_stage_holds, div_valid && !en, div_valid,
        "last pipeline stage lost an item during a stall")
    `SAU_ASSERT_SAME(a_one_field_used,
        o_out_valid && (o_out_item.input_gradient != 16'sd0),
        o_out_item.activation_out == 16'd0, "both result fields are nonzero")
    `SAU_ASSERT_SAME(a_grad_bound, o_out_valid,
        ($signed(o_out_item.input_gradient) <= 16'sd8192) &&
        ($signed(o_out_item.input_gradient) >= -16'sd8192),
        "gradient magnitude above its bound")

endmodule

/* test/sigmoid_activation_unit_top_tb.sv */
// Self-checking testbench for the sigmoid activation unit, forward and backward items.
`timescale 1ns / 1ps

module sigmoid_activation_unit_top_tb import sau_pkg::*; ();

    localparam longint unsigned UNIT_Q30     = 64'd1 << 30;
    localparam longint unsigned EXP_M1_Q30   = 64'd395007542;
    localparam int              SAT_LIMIT    = 30720;
    localparam int              SERIES_TERMS = 13;
    localparam int              DRAIN_CYCLES = 80;
    localparam int              STALL_LIMIT  = 2000;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_item  in_item   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;

    t_out_item   pending_results[$];
    int unsigned mismatch_count = 0;
    int unsigned hold_request   = 0;
    bit          src_idle_on    = 1'b0;
    bit          sink_idle_on   = 1'b0;

    sigmoid_activation_unit_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic longint unsigned exp_neg_fixed(input int unsigned mag);
        longint unsigned whole;
        longint unsigned frac;
        longint unsigned term;
        longint unsigned p;
        longint          acc;
        longint unsigned n;
        whole = (mag >> 10) & 31;
        frac  = longint'(mag & 1023) << 20;
        term  = UNIT_Q30;
        acc   = longint'(UNIT_Q30);
        for (n = 1; n <= SERIES_TERMS; n++) begin
            term = ((term * frac) >> 30) / n;
            if (n[0]) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        p = (acc > 0) ? longint'(acc) : 64'd0;
        for (n = 0; n < whole; n++) begin
            p = (p * EXP_M1_Q30) >> 30;
        end
        return p;
    endfunction

    function automatic logic [15:0] sigmoid_value(input logic signed [15:0] x_in);
        int              x;
        int unsigned     mag;
        longint unsigned p;
        longint unsigned d;
        longint unsigned q;
        x = x_in;
        if (x > SAT_LIMIT) begin
            x = SAT_LIMIT;
        end
        if (x < -SAT_LIMIT) begin
            x = -SAT_LIMIT;
        end
        mag = (x < 0) ? -x : x;
        p   = exp_neg_fixed(mag);
        d   = UNIT_Q30 + p;
        if (x > 0) begin
            q = ((UNIT_Q30 << 16) + d / 2) / d;
        end else begin
            q = ((p << 16) + d / 2) / d;
        end
        if (q > 64'd65535) begin
            q = 64'd65535;
        end
        return q[15:0];
    endfunction

    function automatic logic [15:0] gradient_value(input logic [15:0] y,
                                                   input logic signed [15:0] g);
        longint unsigned spread;
        longint unsigned mag;
        longint unsigned prod;
        spread = (64'd65536 - longint'(y)) * longint'(y);
        mag    = (g < 0) ? longint'(-int'(g)) : longint'(g);
        prod   = (spread * mag) >> 32;
        if (g < 0) begin
            prod = 64'd0 - prod;
        end
        return prod[15:0];
    endfunction

    function automatic t_out_item predict_result(input t_in_item item);
        t_out_item res;
        res = '0;
        if (item.opcode == OP_FORWARD) begin
            res.activation_out = sigmoid_value(item.pre_activation);
        end else begin
            res.input_gradient = gradient_value(item.activation, item.upstream_gradient);
        end
        return res;
    endfunction

    function automatic t_in_item make_item(input logic op, input int x, input int y,
                                           input int g);
        t_in_item item;
        item.opcode            = op;
        item.pre_activation    = x[15:0];
        item.activation        = y[15:0];
        item.upstream_gradient = g[15:0];
        return item;
    endfunction

    function automatic t_in_item random_item();
        t_in_item item;
        int       x;
        int       y;
        item = make_item(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom);
        case ($urandom_range(0, 9)) inside
            [0:5]:   x = int'($urandom_range(0, 61440)) - SAT_LIMIT;
            [6:7]:   x = int'($urandom_range(0, 4095)) - 2048;
            default: x = $urandom;
        endcase
        case ($urandom_range(0, 7))
            0:       y = $urandom_range(0, 15);
            1:       y = $urandom_range(65520, 65535);
            2:       y = $urandom_range(32760, 32776);
            default: y = $urandom;
        endcase
        item.pre_activation = x[15:0];
        item.activation     = y[15:0];
        return item;
    endfunction

    task automatic send_item(input t_in_item item);
        int unsigned gap;
        in_valid <= 1'b1;
        in_item  <= item;
        @(posedge clk);
        while (!in_ready) begin
            @(posedge clk);
        end
        pending_results.push_back(predict_result(item));
        if (src_idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 16);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic test_forward_edges();
        int xs[14] = '{0, 1, -1, 1023, 1024, -1024, 12288, -12288,
                       30720, -30720, 30721, -30721, 32767, -32768};
        foreach (xs[i]) begin
            send_item(make_item(OP_FORWARD, xs[i], $urandom, $urandom));
        end
    endtask

    task automatic test_backward_edges();
        int ys[5] = '{0, 1, 32768, 65535, 16384};
        int gs[5] = '{32767, -32768, 0, -1, 1};
        foreach (ys[i]) begin
            send_item(make_item(OP_BACKWARD, $urandom, ys[i], gs[i]));
        end
        send_item(make_item(OP_BACKWARD, $urandom, 32768, 32767));
        send_item(make_item(OP_BACKWARD, $urandom, 32768, -32768));
    endtask

    task automatic test_random_traffic();
        int unsigned blk;
        for (blk = 0; blk < 9; blk++) begin
            src_idle_on  = ($urandom_range(0, 2) != 0);
            sink_idle_on = ($urandom_range(0, 2) != 0);
            repeat (50) send_item(random_item());
        end
    endtask

    task automatic test_output_stall();
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        hold_request = 300;
        repeat (150) send_item(random_item());
    endtask

    task automatic test_full_rate();
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        repeat (100) send_item(random_item());
    endtask

    initial begin
        forever begin
            @(posedge clk);
            if (hold_request != 0) begin
                out_ready <= 1'b0;
                repeat (hold_request) @(posedge clk);
                hold_request = 0;
                out_ready <= 1'b1;
            end else if (sink_idle_on && $urandom_range(0, 3) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
                out_ready <= 1'b1;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result, actual %h", $time, out_item);
            end else begin
                want = pending_results.pop_front();
                if (out_item.activation_out !== want.activation_out) begin
                    mismatch_count++;
                    $display("%0t: activation_out expected %0d actual %0d", $time,
                             want.activation_out, out_item.activation_out);
                end
                if (out_item.input_gradient !== want.input_gradient) begin
                    mismatch_count++;
                    $display("%0t: input_gradient expected %0d actual %0d", $time,
                             want.input_gradient, out_item.input_gradient);
                end
            end
        end
    end

    initial begin
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("sigmoid_activation_unit_top_tb: done, errors");
        $finish;
    end

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        test_forward_edges();
        test_backward_edges();
        test_random_traffic();
        test_output_stall();
        test_full_rate();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("sigmoid_activation_unit_top_tb: done, clean");
        end else begin
            $display("sigmoid_activation_unit_top_tb: done, errors");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hdl
hdl/sau_pkg.sv
hdl/sau_front.sv
hdl/sau_series.sv
hdl/sau_scale.sv
hdl/sau_div.sv
hdl/sigmoid_activation_unit_top.sv
test/sigmoid_activation_unit_top_tb.sv
